[rtl/mshct_pkg.sv]
// ----------------------------------------------------------------------------
// mshct_pkg : shared types and constants for the mode-select tuner
// Field widths, payload structs, mode and register codes, shared ALU ports.
// ----------------------------------------------------------------------------
package mshct_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;

  localparam int unsigned FB_W    = 17;  // Q1.16 residency
  localparam int unsigned CNT_W   = 32;  // migration / enumeration counts
  localparam int unsigned VAL_W   = 32;  // signed Q16.16
  localparam int unsigned CHURN_W = 24;  // Q8.16 churn limit
  localparam int unsigned VIDX_W  = 4;

  localparam int unsigned PROD_W = CHURN_W + CNT_W;
  localparam int unsigned ALU_W  = PROD_W + 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = CHURN_W;

  localparam logic [FB_W-1:0]    LOW_RES_RST    = FB_W'(36045);
  localparam logic [FB_W-1:0]    HIGH_RES_RST   = FB_W'(55706);
  localparam logic [CHURN_W-1:0] CHURN_LIM_RST  = CHURN_W'(22938);

  localparam logic KIND_TUNE = 1'b0;
  localparam logic KIND_ADD  = 1'b1;

  localparam logic ADD_OK   = 1'b0;
  localparam logic ADD_FULL = 1'b1;

  typedef enum logic [1:0] {
    MODE_BALANCED     = 2'd0,
    MODE_AGGRESSIVE   = 2'd1,
    MODE_CONSERVATIVE = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_RES     = 2'd0,
    CFG_HIGH_RES    = 2'd1,
    CFG_CHURN_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic                    kind;
    logic [FB_W-1:0]         feedback;
    logic [CNT_W-1:0]        migrations;
    logic [CNT_W-1:0]        enumerated;
    logic signed [VAL_W-1:0] init_value;
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] max_value;
    logic signed [VAL_W-1:0] step_size;
  } in_item_t;

  typedef struct packed {
    mode_t                   mode;
    logic                    add_status;
    logic                    visited_valid;
    logic                    value_moved;
    logic [VIDX_W-1:0]       visited_index;
    logic signed [VAL_W-1:0] visited_value;
  } out_item_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             lt;   // a < b for operands extended to ALU_W
    logic             eq;
  } alu_rsp_t;

endpackage

[rtl/mshct_alu.sv]
// ----------------------------------------------------------------------------
// mshct_alu : shared add / subtract and compare unit
// Operands arrive already extended; sign of the difference gives less-than.
// ----------------------------------------------------------------------------
module mshct_alu
  import mshct_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W-1:0] res;

  always_comb begin
    case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_SUB: res = req.a - req.b;
      default: res = req.a - req.b;
    endcase
  end

  assign rsp.res = res;
  assign rsp.lt  = res[ALU_W-1];
  assign rsp.eq  = (res == '0);

endmodule

[rtl/mode_select_hill_climb_tuner_core.sv]
// ----------------------------------------------------------------------------
// mode_select_hill_climb_tuner_core : mode selector and round-robin tuner
// Add beats load entries; tune beats set the mode and arm or step one entry.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  in_item_t  (add or tune)
//   out_     out  out_valid/out_stall out_item_t (one per input beat)
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// An add beat passes through S_DONE alone; a tune on an empty table or a
// first visit passes S_CHURN and S_DONE, and a tune with a step passes
// S_CHURN, S_FB, S_STEP, S_LO, S_HI and S_DONE, as churn compare, feedback
// compare, step and both clamps share the one ALU. The result sits in an
// output register, so the next beat is taken while it waits. in_stall is
// high while an item is in work. Synchronous reset clears the entry count,
// index and mode and loads the register defaults.
// ----------------------------------------------------------------------------
module mode_select_hill_climb_tuner_core
  import mshct_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned NUM_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHURN = 7'b0000010,
    S_FB    = 7'b0000100,
    S_STEP  = 7'b0001000,
    S_LO    = 7'b0010000,
    S_HI    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
    logic signed [VAL_W-1:0] incr;
    logic                    dir_down;
    logic                    armed;
    logic [FB_W-1:0]         last_fb;
  } entry_t;

  // control state
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]   entry_count_r, entry_count_nxt;
  logic [IDX_W-1:0]   next_index_r, next_index_nxt;
  mode_t              mode_r, mode_nxt;
  logic [FB_W-1:0]    low_res_r, low_res_nxt;
  logic [FB_W-1:0]    high_res_r, high_res_nxt;
  logic [CHURN_W-1:0] churn_lim_r, churn_lim_nxt;

  // payload
  in_item_t           item_r, item_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [VAL_W:0]     sum_r, sum_nxt;
  logic               dir_r, dir_nxt;
  out_item_t          res_r, res_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // table
  entry_t             mem [MAX_ENTRIES];
  entry_t             rd_q;
  logic               mem_re;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  logic               accept;
  logic               full;
  logic               out_free;
  logic               churn_below;
  logic               churn_above;
  logic               enu_zero;
  logic               hi_over;
  logic [NUM_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   idx_wrap;
  logic [31:0]        idx_ext;
  logic [VAL_W-1:0]   final_val;

  mshct_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign full     = (entry_count_r == NUM_W'(MAX_ENTRIES));
  assign out_free = !out_valid_r || !out_stall;
  assign enu_zero = (item_r.enumerated == '0);

  // round-robin: next index is always below the count once the table is used
  assign idx_inc  = NUM_W'(next_index_r) + NUM_W'(1);
  assign idx_wrap = (idx_inc == entry_count_r) ? '0 : idx_inc[IDX_W-1:0];
  assign idx_ext  = 32'(next_index_r);

  assign churn_below = enu_zero ? (churn_lim_r != '0) : alu_rsp.lt;
  assign churn_above = !enu_zero && !alu_rsp.lt && !alu_rsp.eq;
  assign hi_over     = !alu_rsp.lt && !alu_rsp.eq;
  assign final_val   = hi_over ? rd_q.high : sum_r[VAL_W-1:0];

  // shared unit operand selection
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state_r)
      S_CHURN: begin
        alu_req.a = ALU_W'({item_r.migrations, 16'h0000});
        alu_req.b = ALU_W'(prod_r);
      end
      S_FB: begin
        alu_req.a = ALU_W'(item_r.feedback);
        alu_req.b = ALU_W'(rd_q.last_fb);
      end
      S_STEP: begin
        alu_req.op = dir_r ? ALU_SUB : ALU_ADD;
        alu_req.a  = {{(ALU_W-VAL_W){rd_q.value[VAL_W-1]}}, rd_q.value};
        alu_req.b  = {{(ALU_W-VAL_W){rd_q.incr[VAL_W-1]}}, rd_q.incr};
      end
      S_LO: begin
        alu_req.a = {{(ALU_W-VAL_W-1){sum_r[VAL_W]}}, sum_r};
        alu_req.b = {{(ALU_W-VAL_W){rd_q.low[VAL_W-1]}}, rd_q.low};
      end
      S_HI: begin
        alu_req.a = {{(ALU_W-VAL_W-1){sum_r[VAL_W]}}, sum_r};
        alu_req.b = {{(ALU_W-VAL_W){rd_q.high[VAL_W-1]}}, rd_q.high};
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    entry_count_nxt = entry_count_r;
    next_index_nxt  = next_index_r;
    mode_nxt        = mode_r;
    low_res_nxt     = low_res_r;
    high_res_nxt    = high_res_r;
    churn_lim_nxt   = churn_lim_r;
    item_nxt        = item_r;
    prod_nxt        = prod_r;
    sum_nxt         = sum_r;
    dir_nxt         = dir_r;
    res_nxt         = res_r;
    out_data_nxt    = out_data_r;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = next_index_r;
    mem_wd          = rd_q;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOW_RES:     low_res_nxt   = cfg_data[FB_W-1:0];
        CFG_HIGH_RES:    high_res_nxt  = cfg_data[FB_W-1:0];
        CFG_CHURN_LIMIT: churn_lim_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          prod_nxt = PROD_W'(churn_lim_r) * PROD_W'(in_data.enumerated);
          res_nxt  = '0;
          if (in_data.kind == KIND_ADD) begin
            if (full) begin
              res_nxt.add_status = ADD_FULL;
            end else begin
              res_nxt.add_status = ADD_OK;
              mem_we          = 1'b1;
              mem_wa          = entry_count_r[IDX_W-1:0];
              mem_wd.value    = in_data.init_value;
              mem_wd.low      = in_data.min_value;
              mem_wd.high     = in_data.max_value;
              mem_wd.incr     = in_data.step_size;
              mem_wd.dir_down = 1'b0;
              mem_wd.armed    = 1'b0;
              mem_wd.last_fb  = '0;
              entry_count_nxt = entry_count_r + NUM_W'(1);
            end
            state_nxt = S_DONE;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_CHURN;
          end
        end
      end
      S_CHURN: begin
        if (item_r.feedback < low_res_r && churn_below) begin
          mode_nxt = MODE_AGGRESSIVE;
        end else if (churn_above && item_r.feedback < high_res_r) begin
          mode_nxt = MODE_CONSERVATIVE;
        end else begin
          mode_nxt = MODE_BALANCED;
        end
        if (entry_count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          res_nxt.visited_valid = 1'b1;
          res_nxt.visited_index = idx_ext[VIDX_W-1:0];
          if (!rd_q.armed) begin
            // first visit only records the feedback
            mem_we                = 1'b1;
            mem_wd.armed          = 1'b1;
            mem_wd.last_fb        = item_r.feedback;
            res_nxt.visited_value = rd_q.value;
            next_index_nxt        = idx_wrap;
            state_nxt             = S_DONE;
          end else begin
            state_nxt = S_FB;
          end
        end
      end
      S_FB: begin
        dir_nxt   = rd_q.dir_down ^ alu_rsp.lt;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        sum_nxt   = alu_rsp.res[VAL_W:0];
        state_nxt = S_LO;
      end
      S_LO: begin
        if (alu_rsp.lt) begin
          sum_nxt = {rd_q.low[VAL_W-1], rd_q.low};
        end
        state_nxt = S_HI;
      end
      S_HI: begin
        mem_we                = 1'b1;
        mem_wd.value          = final_val;
        mem_wd.dir_down       = dir_r;
        mem_wd.last_fb        = item_r.feedback;
        res_nxt.value_moved   = 1'b1;
        res_nxt.visited_value = final_val;
        next_index_nxt        = idx_wrap;
        state_nxt             = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_data_nxt      = res_r;
          out_data_nxt.mode = mode_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= '0;
      next_index_r  <= '0;
      mode_r        <= MODE_BALANCED;
      low_res_r     <= LOW_RES_RST;
      high_res_r    <= HIGH_RES_RST;
      churn_lim_r   <= CHURN_LIM_RST;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      entry_count_r <= entry_count_nxt;
      next_index_r  <= next_index_nxt;
      mode_r        <= mode_nxt;
      low_res_r     <= low_res_nxt;
      high_res_r    <= high_res_nxt;
      churn_lim_r   <= churn_lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    dir_r      <= dir_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // entry table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[next_index_r];
    end
  end

endmodule
